@@ sv/srps_pkg.sv @@
// shared constants and codes for the slotted row page store
package srps_pkg;

   localparam int HDR_BYTES  = 8;
   localparam int SLOT_BYTES = 4;
   localparam int LEN_W      = 13;

   typedef enum logic [1:0] {
      OP_INIT   = 2'd0,
      OP_APPEND = 2'd1,
      OP_READ   = 2'd2,
      OP_COUNT  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_LAYOUT    = 3'd1,
      ST_SLOTFULL  = 3'd2,
      ST_NOSPACE   = 3'd3,
      ST_SLOTRANGE = 3'd4,
      ST_PAYRANGE  = 3'd5,
      ST_EMPTY     = 3'd6,
      ST_POSITION  = 3'd7
   } status_type;

endpackage

@@ sv/srps_ram.sv @@
// generic single write port ram with registered read
module srps_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/slotted_row_page_store_core.sv @@
// slotted page store: sequencer around one shared add and compare unit
// init answers straight from idle; row count, first append byte and read check the layout first,
// later append bytes go straight to the payload write; errors end the sequence early
// each step of the sequencer uses the shared adder/comparator once, so one request at a time
// a new request can be accepted in the cycle its result strobe is high; results cannot stall
// synchronous reset leaves the page unformatted with format version 1; memories are not cleared
module slotted_row_page_store_core
   import srps_pkg::*;
#(
   parameter int PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [9:0]  req_slot_index,
   input  logic [11:0] req_byte_pos,
   input  logic [12:0] req_row_len,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_slot_result,
   output logic [7:0]  rsp_read_byte,
   output logic [12:0] rsp_row_size,
   output logic [9:0]  rsp_rows_stored,
   output logic        rsp_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_format_version
);

   localparam int SLOT_COUNT = (PAGE_BYTES - HDR_BYTES) / SLOT_BYTES;
   localparam int PW = $clog2(PAGE_BYTES + 1);
   localparam int IW = $clog2(PAGE_BYTES);
   localparam int SW = $clog2(SLOT_COUNT);
   localparam int RW = $clog2(SLOT_COUNT + 1);
   localparam int VW = (PW > LEN_W) ? PW : LEN_W;
   localparam int AW = VW + 1;
   localparam int EW = PW + LEN_W;

   typedef enum logic [16:0] {
      S_IDLE   = 17'h00001,
      S_LAYA   = 17'h00002,
      S_LAYB   = 17'h00004,
      S_LAYC   = 17'h00008,
      S_SLOTS  = 17'h00010,
      S_SPACE1 = 17'h00020,
      S_SPACE2 = 17'h00040,
      S_APOFF  = 17'h00080,
      S_APWR   = 17'h00100,
      S_APEND  = 17'h00200,
      S_RDRNG  = 17'h00400,
      S_RDOFF  = 17'h00800,
      S_RDEND1 = 17'h01000,
      S_RDEND2 = 17'h02000,
      S_RDPOS  = 17'h04000,
      S_RDADR  = 17'h08000,
      S_RDDATA = 17'h10000
   } state_type;

   state_type        state_ff, state_in;
   logic [15:0]      version_cfg_ff, version_cfg_in;
   logic [15:0]      stored_version_ff, stored_version_in;
   logic [RW-1:0]    row_total_ff, row_total_in;
   logic [PW-1:0]    free_low_ff, free_low_in;
   logic [PW-1:0]    free_high_ff, free_high_in;
   logic [PW-1:0]    pend_off_ff, pend_off_in;
   logic [LEN_W-1:0] pend_len_ff, pend_len_in;
   logic [LEN_W-1:0] next_pos_ff, next_pos_in;
   logic             append_busy_ff, append_busy_in;
   logic             rsp_valid_ff, rsp_valid_in;

   op_type           op_ff, op_in;
   logic [9:0]       slot_ff, slot_in;
   logic [11:0]      pos_ff, pos_in;
   logic [12:0]      rlen_ff, rlen_in;
   logic [7:0]       data_ff, data_in;
   logic [AW-1:0]    tmp_ff, tmp_in;
   logic [PW-1:0]    off_ff, off_in;
   logic [LEN_W-1:0] sz_ff, sz_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [9:0]       rsp_slot_ff, rsp_slot_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic [12:0]      rsp_size_ff, rsp_size_in;
   logic [9:0]       rsp_rows_ff, rsp_rows_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [AW-1:0]    alu_a, alu_b, alu_res;
   logic             alu_sub, alu_lt, alu_eq;
   logic [AW-1:0]    expect_sum;
   logic             commit;
   logic [EW-1:0]    slot_rd_data;
   logic [7:0]       pay_rd_data;
   logic [PW-1:0]    slot_rd_off;
   logic [LEN_W-1:0] slot_rd_len;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign expect_sum  = AW'(HDR_BYTES) + (AW'(row_total_ff) << 2);
   assign slot_rd_off = slot_rd_data[EW-1:LEN_W];
   assign slot_rd_len = slot_rd_data[LEN_W-1:0];

   // shared add and compare unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      unique case (state_ff)
         S_LAYA: begin
            alu_a = expect_sum;
            alu_b = AW'(free_low_ff);
         end
         S_LAYB: begin
            alu_a = AW'(free_high_ff);
            alu_b = AW'(free_low_ff);
         end
         S_LAYC: begin
            alu_a = AW'(PAGE_BYTES);
            alu_b = AW'(free_high_ff);
         end
         S_SLOTS: begin
            alu_a = AW'(row_total_ff);
            alu_b = AW'(SLOT_COUNT);
         end
         S_SPACE1: begin
            alu_a = AW'(free_high_ff);
            alu_b = AW'(free_low_ff);
         end
         S_SPACE2: begin
            alu_a = tmp_ff;
            alu_b = AW'(rlen_ff) + AW'(SLOT_BYTES);
         end
         S_APOFF: begin
            alu_a = AW'(free_high_ff);
            alu_b = AW'(rlen_ff);
         end
         S_APWR: begin
            alu_a   = AW'(pend_off_ff);
            alu_b   = AW'(pos_ff);
            alu_sub = 1'b0;
         end
         S_APEND: begin
            alu_a = AW'(pos_ff) + AW'(1);
            alu_b = AW'(pend_len_ff);
         end
         S_RDRNG: begin
            alu_a = AW'(slot_ff);
            alu_b = AW'(row_total_ff);
         end
         S_RDOFF: begin
            alu_a = AW'(slot_rd_off);
            alu_b = AW'(free_high_ff);
         end
         S_RDEND1: begin
            alu_a   = AW'(off_ff);
            alu_b   = AW'(sz_ff);
            alu_sub = 1'b0;
         end
         S_RDEND2: begin
            alu_a = AW'(PAGE_BYTES);
            alu_b = tmp_ff;
         end
         S_RDPOS: begin
            alu_a = AW'(pos_ff);
            alu_b = AW'(sz_ff);
         end
         S_RDADR: begin
            alu_a   = AW'(off_ff);
            alu_b   = AW'(pos_ff);
            alu_sub = 1'b0;
         end
         S_RDDATA: begin
            alu_a = AW'(pos_ff) + AW'(1);
            alu_b = AW'(sz_ff);
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign alu_lt  = alu_res[AW-1];
   assign alu_eq  = (alu_res == '0);
   assign commit  = (state_ff == S_APEND) && !alu_lt;

   always_comb begin
      state_in          = state_ff;
      version_cfg_in    = version_cfg_ff;
      stored_version_in = stored_version_ff;
      row_total_in      = row_total_ff;
      free_low_in       = free_low_ff;
      free_high_in      = free_high_ff;
      pend_off_in       = pend_off_ff;
      pend_len_in       = pend_len_ff;
      next_pos_in       = next_pos_ff;
      append_busy_in    = append_busy_ff;
      op_in             = op_ff;
      slot_in           = slot_ff;
      pos_in            = pos_ff;
      rlen_in           = rlen_ff;
      data_in           = data_ff;
      tmp_in            = tmp_ff;
      off_in            = off_ff;
      sz_in             = sz_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = ST_OK;
      rsp_slot_in       = '0;
      rsp_byte_in       = '0;
      rsp_size_in       = '0;
      rsp_rows_in       = '0;
      rsp_last_in       = 1'b0;

      if (csr_valid) begin
         version_cfg_in = csr_format_version;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = op_type'(req_op);
               slot_in = req_slot_index;
               pos_in  = req_byte_pos;
               rlen_in = req_row_len;
               data_in = req_data_byte;
               unique case (op_type'(req_op))
                  OP_INIT: begin
                     stored_version_in = version_cfg_ff;
                     row_total_in      = '0;
                     free_low_in       = PW'(HDR_BYTES);
                     free_high_in      = PW'(PAGE_BYTES);
                     append_busy_in    = 1'b0;
                     next_pos_in       = '0;
                     pend_off_in       = '0;
                     rsp_valid_in      = 1'b1;
                  end
                  OP_APPEND: begin
                     if (req_byte_pos == '0) begin
                        append_busy_in = 1'b0;
                        if (req_row_len == '0) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = ST_EMPTY;
                        end else begin
                           state_in = S_LAYA;
                        end
                     end else if (!append_busy_ff ||
                                  LEN_W'(req_byte_pos) != next_pos_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_POSITION;
                     end else begin
                        state_in = S_APWR;
                     end
                  end
                  OP_READ, OP_COUNT: begin
                     state_in = S_LAYA;
                  end
               endcase
            end
         end
         S_LAYA: begin
            if (!alu_eq || stored_version_ff != version_cfg_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_LAYOUT;
               state_in      = S_IDLE;
            end else begin
               state_in = S_LAYB;
            end
         end
         S_LAYB: begin
            if (alu_lt) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_LAYOUT;
               state_in      = S_IDLE;
            end else begin
               state_in = S_LAYC;
            end
         end
         S_LAYC: begin
            priority if (alu_lt) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_LAYOUT;
               state_in      = S_IDLE;
            end else if (op_ff == OP_APPEND) begin
               state_in = S_SLOTS;
            end else if (op_ff == OP_READ) begin
               state_in = S_RDRNG;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_rows_in  = 10'(row_total_ff);
               state_in     = S_IDLE;
            end
         end
         S_SLOTS: begin
            if (!alu_lt) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_SLOTFULL;
               state_in      = S_IDLE;
            end else begin
               state_in = S_SPACE1;
            end
         end
         S_SPACE1: begin
            tmp_in   = alu_res;
            state_in = S_SPACE2;
         end
         S_SPACE2: begin
            if (alu_lt) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOSPACE;
               state_in      = S_IDLE;
            end else begin
               state_in = S_APOFF;
            end
         end
         S_APOFF: begin
            pend_off_in    = PW'(alu_res);
            pend_len_in    = rlen_ff;
            append_busy_in = 1'b1;
            state_in       = S_APWR;
         end
         S_APWR: begin
            state_in = S_APEND;
         end
         S_APEND: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (commit) begin
               rsp_slot_in    = 10'(row_total_ff);
               rsp_rows_in    = 10'(row_total_ff + RW'(1));
               rsp_last_in    = 1'b1;
               row_total_in   = row_total_ff + RW'(1);
               free_low_in    = free_low_ff + PW'(SLOT_BYTES);
               free_high_in   = pend_off_ff;
               append_busy_in = 1'b0;
               next_pos_in    = '0;
            end else begin
               rsp_rows_in = 10'(row_total_ff);
               next_pos_in = LEN_W'(pos_ff) + LEN_W'(1);
            end
         end
         S_RDRNG: begin
            if (!alu_lt) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_SLOTRANGE;
               state_in      = S_IDLE;
            end else begin
               state_in = S_RDOFF;
            end
         end
         S_RDOFF: begin
            off_in = slot_rd_off;
            sz_in  = slot_rd_len;
            if (alu_lt) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_PAYRANGE;
               state_in      = S_IDLE;
            end else begin
               state_in = S_RDEND1;
            end
         end
         S_RDEND1: begin
            tmp_in   = alu_res;
            state_in = S_RDEND2;
         end
         S_RDEND2: begin
            if (alu_lt) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_PAYRANGE;
               state_in      = S_IDLE;
            end else begin
               state_in = S_RDPOS;
            end
         end
         S_RDPOS: begin
            if (!alu_lt) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_POSITION;
               state_in      = S_IDLE;
            end else begin
               state_in = S_RDADR;
            end
         end
         S_RDADR: begin
            state_in = S_RDDATA;
         end
         S_RDDATA: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = pay_rd_data;
            rsp_size_in  = 13'(sz_ff);
            rsp_rows_in  = 10'(row_total_ff);
            rsp_last_in  = alu_eq;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         version_cfg_ff    <= 16'd1;
         stored_version_ff <= '0;
         row_total_ff      <= '0;
         free_low_ff       <= '0;
         free_high_ff      <= '0;
         pend_off_ff       <= '0;
         pend_len_ff       <= '0;
         next_pos_ff       <= '0;
         append_busy_ff    <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         version_cfg_ff    <= version_cfg_in;
         stored_version_ff <= stored_version_in;
         row_total_ff      <= row_total_in;
         free_low_ff       <= free_low_in;
         free_high_ff      <= free_high_in;
         pend_off_ff       <= pend_off_in;
         pend_len_ff       <= pend_len_in;
         next_pos_ff       <= next_pos_in;
         append_busy_ff    <= append_busy_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      pos_ff        <= pos_in;
      rlen_ff       <= rlen_in;
      data_ff       <= data_in;
      tmp_ff        <= tmp_in;
      off_ff        <= off_in;
      sz_ff         <= sz_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_rows_ff   <= rsp_rows_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // row payload bytes
   srps_ram #(
      .WIDTH (8),
      .DEPTH (PAGE_BYTES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_APWR),
      .wr_addr (IW'(alu_res)),
      .wr_data (data_ff),
      .rd_en   (state_ff == S_RDADR),
      .rd_addr (IW'(alu_res)),
      .rd_data (pay_rd_data)
   );

   // slot entries: offset and size
   srps_ram #(
      .WIDTH (EW),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (SW'(row_total_ff)),
      .wr_data ({pend_off_ff, pend_len_ff}),
      .rd_en   (state_ff == S_RDRNG),
      .rd_addr (SW'(slot_ff)),
      .rd_data (slot_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_result = rsp_slot_ff;
   assign rsp_read_byte   = rsp_byte_ff;
   assign rsp_row_size    = rsp_size_ff;
   assign rsp_rows_stored = rsp_rows_ff;
   assign rsp_last_byte   = rsp_last_ff;

endmodule
